// ----- hdl/exs_pkg.sv -----
`default_nettype none
package exs_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned DEFAULT_CAPACITY = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_RD_I,
    ST_SORT_LD_I,
    ST_SORT_CMP,
    ST_SORT_WB,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } exs_state_t;

endpackage
`default_nettype wire

// ----- hdl/exs_if.sv -----
`default_nettype none
interface exs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [exs_pkg::DATA_W-1:0]   sample_value;
  logic                                is_final;

  modport source (output valid, output sample_value, output is_final, input ready);
  modport sink   (input valid, input sample_value, input is_final, output ready);
endinterface

interface exs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [exs_pkg::DATA_W-1:0]   sorted_value;
  logic                                final_out;
  logic                                overflowed;

  modport source (output valid, output sorted_value, output final_out, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_out, input overflowed,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/exs_store.sv -----
`default_nettype none
module exs_store #(
  parameter int unsigned DEPTH = exs_pkg::DEFAULT_CAPACITY,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [exs_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output      logic [exs_pkg::DATA_W-1:0] rdata_r
);
  import exs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/exchange_sort_ascending.sv -----
`default_nettype none
// Ascending exchange sort of a framed set of signed 32-bit values. Values are
// taken one per cycle into a CAPACITY-entry memory until a transaction with
// is_final arrives; values arriving while the memory is full are dropped and
// every result of that set carries overflowed. The sort then runs on the
// single memory port pair: n values take n(n-1)/2 compares (one read, compare
// and conditional write-back per cycle) plus ST_SORT_RD_I, ST_SORT_LD_I and
// ST_SORT_WB per outer position, then the n results go out in ascending order,
// each read, loaded and held in ST_OUT_HOLD until out_chan.ready is high. No
// input is taken from the final transaction until the last result of the set
// has been delivered. No clearing pass is needed after reset.
module exchange_sort_ascending #(
  parameter int unsigned CAPACITY = exs_pkg::DEFAULT_CAPACITY
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  exs_in_if.sink     in_chan,
  exs_out_if.source  out_chan
);
  import exs_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  exs_state_t state_r, state_nxt;

  logic [CW-1:0]     fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic [AW-1:0]     i_r, i_nxt;
  logic [AW-1:0]     j_r, j_nxt;
  logic [DATA_W-1:0] a_r, a_nxt;

  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic              out_final_r, out_final_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic [CW-1:0]     i_ext, j_ext;
  logic              in_xfer;

  exs_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  assign i_ext   = CW'(i_r);
  assign j_ext   = CW'(j_r);
  assign in_xfer = in_chan.valid && in_chan.ready;

  assign in_chan.ready         = (state_r == ST_LOAD);
  assign out_chan.valid        = (state_r == ST_OUT_HOLD);
  assign out_chan.sorted_value = out_value_r;
  assign out_chan.final_out    = out_final_r;
  assign out_chan.overflowed   = out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    a_r         <= a_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (fill_r < CAP_C) begin
            mem_we    = 1'b1;
            mem_waddr = fill_r[AW-1:0];
            mem_wdata = in_chan.sample_value;
            fill_nxt  = fill_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_chan.is_final) begin
            i_nxt = '0;
            // fill_nxt is at least one here
            if (fill_nxt > CW'(1)) begin
              state_nxt = ST_SORT_RD_I;
            end else begin
              state_nxt = ST_OUT_RD;
            end
          end
        end
      end

      ST_SORT_RD_I: begin
        mem_raddr = i_r;
        state_nxt = ST_SORT_LD_I;
      end

      ST_SORT_LD_I: begin
        a_nxt     = mem_rdata;
        mem_raddr = i_r + AW'(1);
        j_nxt     = i_r + AW'(1);
        state_nxt = ST_SORT_CMP;
      end

      ST_SORT_CMP: begin
        // a_r holds the running value of position i; mem_rdata is position j
        if ($signed(a_r) > $signed(mem_rdata)) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = a_r;
          a_nxt     = mem_rdata;
        end
        if ((j_ext + CW'(1)) < fill_r) begin
          mem_raddr = j_r + AW'(1);
          j_nxt     = j_r + AW'(1);
        end else begin
          state_nxt = ST_SORT_WB;
        end
      end

      ST_SORT_WB: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = a_r;
        if ((i_ext + CW'(2)) < fill_r) begin
          i_nxt     = i_r + AW'(1);
          state_nxt = ST_SORT_RD_I;
        end else begin
          i_nxt     = '0;
          state_nxt = ST_OUT_RD;
        end
      end

      ST_OUT_RD: begin
        mem_raddr = i_r;
        state_nxt = ST_OUT_LD;
      end

      ST_OUT_LD: begin
        out_value_nxt = mem_rdata;
        out_final_nxt = ((i_ext + CW'(1)) == fill_r);
        out_ovf_nxt   = ovf_r;
        state_nxt     = ST_OUT_HOLD;
      end

      ST_OUT_HOLD: begin
        if (out_chan.ready) begin
          if (out_final_r) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- dv/exchange_sort_ascending_checker.sv -----
module exchange_sort_ascending_checker #(
  parameter int unsigned CAPACITY = exs_pkg::DEFAULT_CAPACITY
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  exs_in_if           in_mon,
  exs_out_if          out_mon,
  output int unsigned error_count,
  output int unsigned results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import exs_pkg::*;

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef struct {
    elem_t value;
    logic  last;
    logic  dropped;
  } sorted_result_t;

  elem_t          set_elems [CAPACITY];
  int unsigned    set_fill;
  logic           set_dropped;
  sorted_result_t sorted_due [$];

  initial begin
    error_count = 0;
    results_due = 0;
    set_fill    = 0;
    set_dropped = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    error_count++;
  endtask

  // Pairwise exchange over the held elements; strict compare keeps equal values in place.
  function automatic void exchange_sort_set();
    elem_t held;
    for (int unsigned i = 0; i + 1 < set_fill; i++) begin
      for (int unsigned j = i + 1; j < set_fill; j++) begin
        if (set_elems[i] > set_elems[j]) begin
          held         = set_elems[i];
          set_elems[i] = set_elems[j];
          set_elems[j] = held;
        end
      end
    end
  endfunction

  task automatic take_element(input elem_t value, input logic last);
    sorted_result_t res;
    if (set_fill < CAPACITY) begin
      set_elems[set_fill] = value;
      set_fill++;
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      exchange_sort_set();
      for (int unsigned k = 0; k < set_fill; k++) begin
        res.value   = set_elems[k];
        res.last    = (k + 1 == set_fill);
        res.dropped = set_dropped;
        sorted_due.push_back(res);
      end
      set_fill    = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic check_result(input elem_t value, input logic last, input logic dropped);
    sorted_result_t want;
    if (sorted_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result value=%0d final_out=%b overflowed=%b",
                                value, last, dropped));
      return;
    end
    want = sorted_due.pop_front();
    if (value !== want.value)
      report_mismatch($sformatf("sorted_value %0d, want %0d", value, want.value));
    if (last !== want.last)
      report_mismatch($sformatf("final_out %b, want %b (value %0d)", last, want.last,
                                want.value));
    if (dropped !== want.dropped)
      report_mismatch($sformatf("overflowed %b, want %b (value %0d)", dropped, want.dropped,
                                want.value));
  endtask

  // Input side is handled first so a result in the same cycle sees its expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      set_fill    = 0;
      set_dropped = 1'b0;
      sorted_due.delete();
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        take_element(in_mon.sample_value, in_mon.is_final);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
        check_result(out_mon.sorted_value, out_mon.final_out, out_mon.overflowed);
    end
    results_due = sorted_due.size();
  end

endmodule

// ----- dv/exchange_sort_ascending_test.sv -----
module exchange_sort_ascending_test;
  timeunit 1ns;
  timeprecision 1ps;
  import exs_pkg::*;

  localparam int unsigned CAPACITY     = DEFAULT_CAPACITY;
  localparam int unsigned ITEM_BUDGET  = 500;
  localparam int unsigned NUM_PHASES   = 4;
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef logic signed [DATA_W-1:0] elem_t;

  localparam elem_t MAX_VALUE = 32'sh7FFF_FFFF;
  localparam elem_t MIN_VALUE = 32'sh8000_0000;

  // sender idle / receiver stall percentages per phase
  localparam int unsigned IDLE_PCT  [NUM_PHASES] = '{0, 78, 0, 27};
  localparam int unsigned STALL_PCT [NUM_PHASES] = '{0, 0, 78, 27};

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned error_count;
  int unsigned results_due;

  exs_in_if  in_chan ();
  exs_out_if out_chan ();

  exchange_sort_ascending #(.CAPACITY(CAPACITY)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  exchange_sort_ascending_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .error_count (error_count),
    .results_due (results_due)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #20ms;
    $display("exchange_sort_ascending_test: errors");
    $finish;
  end

  task automatic send_item(input elem_t value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.sample_value <= value;
    in_chan.is_final     <= last;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    items_sent++;
  endtask

  // Sends one data set; the last element carries is_final.
  task automatic send_set(input elem_t elems [$]);
    foreach (elems[k])
      send_item(elems[k], k == elems.size() - 1);
  endtask

  function automatic elem_t pick_value(input elem_t prev);
    int unsigned r;
    elem_t       v;
    r = $urandom_range(99);
    if (r < 55) begin
      v = $urandom;
    end else if (r < 72) begin
      v = $urandom_range(8);
      v = v - 4;
    end else if (r < 88) begin
      case ($urandom_range(4))
        0:       v = MAX_VALUE;
        1:       v = MIN_VALUE;
        2:       v = 0;
        3:       v = -1;
        default: v = 1;
      endcase
    end else begin
      v = prev;
    end
    return v;
  endfunction

  // forced_len of zero picks a mostly small size, now and then a full or overflowing set.
  task automatic send_random_set(input int unsigned forced_len);
    int unsigned r;
    int unsigned set_len;
    elem_t       prev;
    elem_t       elems [$];
    set_len = forced_len;
    if (set_len == 0) begin
      r = $urandom_range(99);
      if (r < 80)      set_len = $urandom_range(8, 1);
      else if (r < 93) set_len = $urandom_range(30, 9);
      else if (r < 97) set_len = CAPACITY;
      else             set_len = $urandom_range(CAPACITY + 6, CAPACITY + 1);
    end
    prev = 0;
    for (int unsigned k = 0; k < set_len; k++) begin
      prev = pick_value(prev);
      elems.push_back(prev);
    end
    send_set(elems);
  endtask

  initial begin
    elem_t dir_set [$];
    in_chan.valid        = 1'b0;
    in_chan.sample_value = '0;
    in_chan.is_final     = 1'b0;
    out_chan.ready       = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element sets at both extremes
    dir_set = {MAX_VALUE};
    send_set(dir_set);
    dir_set = {MIN_VALUE};
    send_set(dir_set);
    // extremes, alternating bit patterns and equal elements
    dir_set = {elem_t'(0), elem_t'(-1), MAX_VALUE, MIN_VALUE, elem_t'(32'sh5555_5555),
               elem_t'(7), elem_t'(32'shAAAA_AAAA), elem_t'(7), elem_t'(-1), MIN_VALUE};
    send_set(dir_set);
    // reverse order, then already in order
    dir_set = {elem_t'(5), elem_t'(4), elem_t'(3), elem_t'(2), elem_t'(1)};
    send_set(dir_set);
    dir_set = {elem_t'(-3), elem_t'(-2), elem_t'(-1)};
    send_set(dir_set);
    dir_set = {elem_t'(9), elem_t'(9)};
    send_set(dir_set);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      idle_pct  = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      // make sure a full set and a set with dropped elements always occur
      if (p == 1)
        send_random_set(CAPACITY);
      else if (p == 2)
        send_random_set(CAPACITY + 2);
      while (items_sent < (p + 1) * ITEM_BUDGET / NUM_PHASES)
        send_random_set(0);
    end
    in_chan.valid <= 1'b0;

    // the checker counts the last set at the same edge, so look only after it settles
    do @(negedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("exchange_sort_ascending_test: clean");
    else
      $display("exchange_sort_ascending_test: errors");
    $finish;
  end

endmodule
